// File: rtl/wbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  localparam int PAT_BYTES  = 32;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W     = 64;
  localparam int OFF_FLD_W  = 32;

  localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4,
    REG_BASE      = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_ZERO_BASE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } scan_in_t;

  typedef struct packed {
    status_e               status;
    logic [OFF_FLD_W-1:0]  match_offset;
    logic [ADDR_W-1:0]     match_address;
  } scan_out_t;

  // per-transaction control shared by all cells of the chain
  typedef struct packed {
    logic adv;
    logic clr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/wbps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          pat_i,
  input  logic                en_i,
  input  logic                tail_i,
  output logic                state_o,
  output logic                tail_hit_o
);
  import wbps_pkg::*;

  logic hit;
  logic nxt;
  logic match_q;
  logic match_d;

  assign hit        = (pat_i == WILDCARD_BYTE) || (pat_i == data_i);
  assign nxt        = prev_i & hit & en_i;
  assign tail_hit_o = nxt & tail_i;
  assign state_o    = match_q;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.adv) begin
      match_d = ctrl_i.clr ? 1'b0 : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wbps_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module wbps_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  input  wbps_pkg::status_e             res_status_i,
  input  logic [wbps_pkg::ADDR_W-1:0]   res_offset_i,
  input  logic [wbps_pkg::ADDR_W-1:0]   base_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  output wbps_pkg::scan_out_t           out_data_o,
  input  logic                          out_stall_i
);
  import wbps_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  status_e           s1_status_q;
  logic [ADDR_W-1:0] s1_off_q;
  logic              s2_valid_q, s2_valid_d;
  scan_out_t         s2_data_q;
  logic              s2_ready;
  logic              s1_ready;

  assign s2_ready    = !s2_valid_q || !out_stall_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign ready_o     = s1_ready;
  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (s1_ready) begin
      s1_valid_d = res_valid_i;
    end
    if (s2_ready) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // base add sits in its own stage, away from the offset subtract
  always_ff @(posedge clk_i) begin
    if (s1_ready && res_valid_i) begin
      s1_status_q <= res_status_i;
      s1_off_q    <= res_offset_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_data_q.status       <= s1_status_q;
      s2_data_q.match_offset <= s1_off_q[OFF_FLD_W-1:0];
      s2_data_q.match_address <= (s1_status_q == ST_FOUND) ? (base_i + s1_off_q)
                                                           : '0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && out_stall_i) |-> !ready_o)
    else $error("result stage accepted while full and stalled");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> s2_valid_q)
    else $error("pending result was dropped between stages");

  a_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_FOUND) |->
      (out_data_o.match_offset == '0 && out_data_o.match_address == '0))
    else $error("non-found result carries an offset or address");

endmodule

`default_nettype wire

// File: rtl/wildcard_byte_pattern_scanner_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A result passes through the registered result stages s1 and s2, in that order, before it leaves the output register.
// Throughput: one byte per cycle while in_stall_o is low; the cell chain updates every match bit in the same cycle.
// The output side has two result stages, so input stalls only when both are full.
// Reset clears the match vector, byte position, match flag, config registers and
// both result stages; no clearing pass is needed.
module wildcard_byte_pattern_scanner_top #(
  parameter int MAX_PATTERN  = 32,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wbps_pkg::scan_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wbps_pkg::scan_out_t             out_data_o
);
  import wbps_pkg::*;

  localparam int Cap = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

  logic [CFG_DATA_W-1:0] pat0_q, pat1_q, pat2_q, pat3_q;
  logic [LEN_W-1:0]      pat_len_q;
  logic [ADDR_W-1:0]     base_q;

  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic                    reported_q, reported_d;

  logic [8*PAT_BYTES-1:0]  pat_all;
  logic [LEN_W-1:0]        len_eff;
  logic [LEN_W-1:0]        len_m1;
  logic                    search_active;
  logic                    in_acc;
  logic                    ready;
  logic                    found;
  logic                    res_valid;
  status_e                 res_status;
  logic [OFFSET_WIDTH-1:0] off;
  logic [ADDR_W-1:0]       res_off;
  cell_ctrl_t              cell_ctrl;
  logic [Cap-1:0]          vec_state;
  logic [Cap-1:0]          tail_hits;

  assign pat_all       = {pat3_q, pat2_q, pat1_q, pat0_q};
  assign len_eff       = (pat_len_q > LEN_W'(Cap)) ? LEN_W'(Cap) : pat_len_q;
  assign len_m1        = len_eff - LEN_W'(1);
  assign search_active = !reported_q && (len_eff != '0) && (base_q != '0);

  assign in_stall_o = !ready;
  assign in_acc     = in_valid_i && ready;

  assign cell_ctrl.adv = in_acc;
  assign cell_ctrl.clr = in_data_i.last_byte || !search_active;

  for (genvar j = 0; j < Cap; j++) begin : g_cell
    logic prev;
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = vec_state[j-1];
    end
    wbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .prev_i     (prev),
      .data_i     (in_data_i.data_byte),
      .pat_i      (pat_all[8*j +: 8]),
      .en_i       (LEN_W'(j) < len_eff),
      .tail_i     (LEN_W'(j) == len_m1),
      .state_o    (vec_state[j]),
      .tail_hit_o (tail_hits[j])
    );
  end

  assign found = search_active && (|tail_hits);
  assign off   = pos_q - OFFSET_WIDTH'(len_m1);

  always_comb begin
    res_valid  = in_acc && (found || (in_data_i.last_byte && !reported_q));
    res_status = ST_NOT_FOUND;
    res_off    = '0;
    priority if (found) begin
      res_status = ST_FOUND;
      res_off    = ADDR_W'(off);
    end else if (len_eff == '0) begin
      res_status = ST_EMPTY;
    end else if (base_q == '0) begin
      res_status = ST_ZERO_BASE;
    end else begin
      res_status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    pos_d      = pos_q;
    reported_d = reported_q;
    if (in_acc) begin
      if (in_data_i.last_byte) begin
        pos_d      = '0;
        reported_d = 1'b0;
      end else begin
        if (pos_q != '1) begin
          pos_d = pos_q + OFFSET_WIDTH'(1);
        end
        if (found) begin
          reported_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      reported_q <= 1'b0;
      pat0_q     <= '0;
      pat1_q     <= '0;
      pat2_q     <= '0;
      pat3_q     <= '0;
      pat_len_q  <= '0;
      base_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      reported_q <= reported_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PAT_0_7:   pat0_q    <= cfg_data_i;
          REG_PAT_8_15:  pat1_q    <= cfg_data_i;
          REG_PAT_16_23: pat2_q    <= cfg_data_i;
          REG_PAT_24_31: pat3_q    <= cfg_data_i;
          REG_PAT_LEN:   pat_len_q <= cfg_data_i[LEN_W-1:0];
          REG_BASE:      base_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  wbps_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_status_i (res_status),
    .res_offset_i (res_off),
    .base_i       (base_q),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

  a_found_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && found && !in_data_i.last_byte) |=> reported_q)
    else $error("match flag not set after a match");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_byte) |=> (pos_q == '0 && !reported_q && vec_state == '0))
    else $error("region state not cleared after final byte");

  a_idle_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !search_active) |=> (vec_state == '0))
    else $error("match vector kept while search is off");

  a_one_per_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reported_q && in_acc) |-> !res_valid)
    else $error("second result in one region");

endmodule

`default_nettype wire
